// ===== rtl/depth_first_graph_walk_top_macros.svh =====
// Assertion shorthands for the graph walk checker.
`ifndef DEPTH_FIRST_GRAPH_WALK_TOP_MACROS_SVH
`define DEPTH_FIRST_GRAPH_WALK_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define DFGW_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define DFGW_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/dfgw_pkg.sv =====
package dfgw_pkg;

	localparam int VTX_W = 6;
	localparam int ACT_W = 2;

	localparam logic [ACT_W-1:0] ACT_APPEND = 2'd0;
	localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;
	localparam logic [ACT_W-1:0] ACT_IGNORE = 2'd3;

	typedef struct packed {
		logic             cnt_rd;
		logic             nbr_rd;
		logic             edge_wr;
		logic             clear;
		logic [VTX_W-1:0] vtx;
		logic [VTX_W-1:0] dst;
	} dfgw_gcmd_t;

	typedef struct packed {
		logic             push;
		logic             pop;
		logic [VTX_W-1:0] data;
	} dfgw_scmd_t;

endpackage

// ===== rtl/dfgw_cmd_if.sv =====
interface dfgw_cmd_if import dfgw_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ACT_W-1:0] action;
	logic [VTX_W-1:0] from_vertex;
	logic [VTX_W-1:0] to_vertex;

	modport source (output valid, output action, output from_vertex, output to_vertex,
		input ready);
	modport sink (input valid, input action, input from_vertex, input to_vertex,
		output ready);
endinterface

// ===== rtl/dfgw_visit_if.sv =====
interface dfgw_visit_if import dfgw_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [VTX_W-1:0] vertex;
	logic             last;
	logic             edges_dropped;

	modport source (output valid, output vertex, output last, output edges_dropped,
		input ready);
	modport sink (input valid, input vertex, input last, input edges_dropped,
		output ready);
endinterface

// ===== rtl/dfgw_graph.sv =====
module dfgw_graph import dfgw_pkg::*; #(
	parameter int VERTICES   = 64,
	parameter int MAX_DEGREE = 8,
	localparam int CNT_W     = $clog2(MAX_DEGREE + 1),
	localparam int KI_W      = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dfgw_gcmd_t       gcmd,
	input  logic [KI_W-1:0]  k,
	output logic [CNT_W-1:0] cnt,
	output logic [VTX_W-1:0] nbr
);

	localparam int IDX_W     = $clog2(VERTICES);
	localparam int TBL_DEPTH = VERTICES * MAX_DEGREE;
	localparam int TBL_AW    = $clog2(TBL_DEPTH);

	logic [CNT_W-1:0]  count_mem [VERTICES];
	logic [VTX_W-1:0]  tbl_mem [TBL_DEPTH];
	logic [VERTICES-1:0] cvalid_q;
	logic              cvld_q;
	logic [CNT_W-1:0]  cnt_rd_q;
	logic [VTX_W-1:0]  nbr_q;
	logic [IDX_W-1:0]  vtx_idx;
	logic [TBL_AW-1:0] wr_addr;
	logic [TBL_AW-1:0] rd_addr;

	assign vtx_idx = gcmd.vtx[IDX_W-1:0];
	assign cnt     = cvld_q ? cnt_rd_q : '0;
	assign nbr     = nbr_q;
	assign wr_addr = TBL_AW'(int'(vtx_idx) * MAX_DEGREE + int'(cnt));
	assign rd_addr = TBL_AW'(int'(vtx_idx) * MAX_DEGREE + int'(k));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cvalid_q <= '0;
			cvld_q   <= 1'b0;
		end else begin
			if (gcmd.clear) begin
				cvalid_q <= '0;
			end else if (gcmd.edge_wr) begin
				cvalid_q[vtx_idx] <= 1'b1;
			end
			if (gcmd.cnt_rd) begin
				cvld_q <= cvalid_q[vtx_idx];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (gcmd.edge_wr) begin
			count_mem[vtx_idx] <= CNT_W'(cnt + 1'b1);
		end
		if (gcmd.cnt_rd) begin
			cnt_rd_q <= count_mem[vtx_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (gcmd.edge_wr) begin
			tbl_mem[wr_addr] <= gcmd.dst;
		end
		if (gcmd.nbr_rd) begin
			nbr_q <= tbl_mem[rd_addr];
		end
	end

endmodule

// ===== rtl/dfgw_stack.sv =====
module dfgw_stack import dfgw_pkg::*; #(
	parameter int DEPTH = 513
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dfgw_scmd_t       scmd,
	output logic             empty,
	output logic [VTX_W-1:0] top_data
);

	localparam int LVL_W = $clog2(DEPTH + 1);
	localparam int SA_W  = $clog2(DEPTH);

	logic [VTX_W-1:0] stk_mem [DEPTH];
	logic [LVL_W-1:0] level_q;
	logic [VTX_W-1:0] rd_q;
	logic [LVL_W-1:0] level_dn;

	assign empty    = (level_q == '0);
	assign top_data = rd_q;
	assign level_dn = level_q - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else if (scmd.push && (int'(level_q) < DEPTH)) begin
			level_q <= level_q + 1'b1;
		end else if (scmd.pop && !empty) begin
			level_q <= level_dn;
		end
	end

	always_ff @(posedge clk) begin
		if (scmd.push && (int'(level_q) < DEPTH)) begin
			stk_mem[level_q[SA_W-1:0]] <= scmd.data;
		end
		if (scmd.pop && !empty) begin
			rd_q <= stk_mem[level_dn[SA_W-1:0]];
		end
	end

endmodule

// ===== rtl/depth_first_graph_walk_top.sv =====
// Depth-first graph walk. Append items add one edge to the end of the source's
// neighbor list (an edge past MAX_DEGREE is dropped and sets the sticky
// edges_dropped flag); a clear item empties all lists and clears the flag; a
// search item emits every vertex reachable from its start in depth-first order,
// with last set on the final one. Lists and the walk stack sit in single-port
// synchronous memories with registered reads. A clear or ignored item is done
// in the idle state; an append reads the list's count and then writes the edge
// in S_APPEND; a search passes each vertex through S_VISIT and S_NBR and each
// stack pop through S_POP and S_POPW, and an output stall holds the walk.
// No clearing pass is needed after reset. A new item is taken while the last
// result of a search still waits at the output.
module depth_first_graph_walk_top import dfgw_pkg::*; #(
	parameter int VERTICES   = 64,
	parameter int MAX_DEGREE = 8
) (
	input logic           clk,
	input logic           arst_n,
	dfgw_cmd_if.sink      cmd,
	dfgw_visit_if.source  visit
);

	localparam int IDX_W     = $clog2(VERTICES);
	localparam int CNT_W     = $clog2(MAX_DEGREE + 1);
	localparam int KI_W      = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
	localparam int STK_DEPTH = VERTICES * MAX_DEGREE + 1;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_APPEND = 3'd1;
	localparam logic [2:0] S_VISIT  = 3'd2;
	localparam logic [2:0] S_NBR    = 3'd3;
	localparam logic [2:0] S_POP    = 3'd4;
	localparam logic [2:0] S_POPW   = 3'd5;

	logic [2:0]          state_q;
	logic [VERTICES-1:0] visited_q;
	logic [VTX_W-1:0]    u_q;
	logic [VTX_W-1:0]    a_src_q;
	logic [VTX_W-1:0]    a_dst_q;
	logic [CNT_W-1:0]    k_q;
	logic                rdv_s1;
	logic                dropped_q;
	logic                hold_valid_q;
	logic [VTX_W-1:0]    hold_q;
	logic                out_valid_q;
	logic [VTX_W-1:0]    out_vertex_q;
	logic                out_last_q;
	logic                out_drop_q;

	dfgw_gcmd_t          gcmd;
	dfgw_scmd_t          scmd;
	logic [CNT_W-1:0]    cnt;
	logic [VTX_W-1:0]    nbr;
	logic                stk_empty;
	logic [VTX_W-1:0]    stk_data;

	logic cmd_acc;
	logic src_ok;
	logic dst_ok;
	logic out_free;
	logic issue;
	logic nbr_new;
	logic visit_go;
	logic finish;
	logic load_out;
	logic pop_new;

	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign src_ok    = int'(cmd.from_vertex) < VERTICES;
	assign dst_ok    = int'(cmd.to_vertex) < VERTICES;
	assign out_free  = !out_valid_q || visit.ready;
	assign issue     = (state_q == S_NBR) && (k_q < cnt);
	assign nbr_new   = rdv_s1 && (int'(nbr) < VERTICES) && !visited_q[nbr[IDX_W-1:0]];
	assign visit_go  = (state_q == S_VISIT) && (!hold_valid_q || out_free);
	assign finish    = (state_q == S_POP) && stk_empty && out_free;
	assign load_out  = (visit_go && hold_valid_q) || finish;
	assign pop_new   = (int'(stk_data) < VERTICES) && !visited_q[stk_data[IDX_W-1:0]];

	assign visit.valid         = out_valid_q;
	assign visit.vertex        = out_vertex_q;
	assign visit.last          = out_last_q;
	assign visit.edges_dropped = out_drop_q;

	always_comb begin
		gcmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_acc && (cmd.action == ACT_APPEND) && src_ok && dst_ok) begin
					gcmd.cnt_rd = 1'b1;
					gcmd.vtx    = cmd.from_vertex;
				end
				if (cmd_acc && (cmd.action == ACT_CLEAR)) begin
					gcmd.clear = 1'b1;
				end
			end
			S_APPEND: begin
				gcmd.vtx     = a_src_q;
				gcmd.dst     = a_dst_q;
				gcmd.edge_wr = int'(cnt) < MAX_DEGREE;
			end
			S_VISIT: begin
				gcmd.vtx    = u_q;
				gcmd.cnt_rd = visit_go;
			end
			S_NBR: begin
				gcmd.vtx    = u_q;
				gcmd.nbr_rd = issue;
			end
			default: begin
				gcmd = '0;
			end
		endcase
	end

	assign scmd.push = (state_q == S_NBR) && nbr_new;
	assign scmd.pop  = (state_q == S_POP) && !stk_empty;
	assign scmd.data = nbr;

	dfgw_graph #(
		.VERTICES   (VERTICES),
		.MAX_DEGREE (MAX_DEGREE)
	) u_graph (
		.clk    (clk),
		.arst_n (arst_n),
		.gcmd   (gcmd),
		.k      (k_q[KI_W-1:0]),
		.cnt    (cnt),
		.nbr    (nbr)
	);

	dfgw_stack #(
		.DEPTH (STK_DEPTH)
	) u_stack (
		.clk      (clk),
		.arst_n   (arst_n),
		.scmd     (scmd),
		.empty    (stk_empty),
		.top_data (stk_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			visited_q    <= '0;
			k_q          <= '0;
			rdv_s1       <= 1'b0;
			dropped_q    <= 1'b0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (visit.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_acc) begin
						unique case (cmd.action)
							ACT_APPEND: begin
								if (src_ok && dst_ok) begin
									state_q <= S_APPEND;
								end
							end
							ACT_SEARCH: begin
								if (src_ok) begin
									visited_q <= '0;
									state_q   <= S_VISIT;
								end
							end
							ACT_CLEAR: begin
								dropped_q <= 1'b0;
							end
							ACT_IGNORE: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_APPEND: begin
					if (int'(cnt) >= MAX_DEGREE) begin
						dropped_q <= 1'b1;
					end
					state_q <= S_IDLE;
				end
				S_VISIT: begin
					if (visit_go) begin
						visited_q[u_q[IDX_W-1:0]] <= 1'b1;
						hold_valid_q <= 1'b1;
						k_q          <= '0;
						rdv_s1       <= 1'b0;
						state_q      <= S_NBR;
					end
				end
				S_NBR: begin
					rdv_s1 <= issue;
					if (issue) begin
						k_q <= k_q + 1'b1;
					end else if (!rdv_s1) begin
						state_q <= S_POP;
					end
				end
				S_POP: begin
					if (!stk_empty) begin
						state_q <= S_POPW;
					end else if (out_free) begin
						hold_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				S_POPW: begin
					state_q <= pop_new ? S_VISIT : S_POP;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			a_src_q <= cmd.from_vertex;
			a_dst_q <= cmd.to_vertex;
			u_q     <= cmd.from_vertex;
		end else if ((state_q == S_POPW) && pop_new) begin
			u_q <= stk_data;
		end
		if (visit_go) begin
			hold_q <= u_q;
		end
		if (load_out) begin
			out_vertex_q <= hold_q;
			out_last_q   <= finish;
			out_drop_q   <= dropped_q;
		end
	end

endmodule

// ===== rtl/dfgw_checker.sv =====
`include "depth_first_graph_walk_top_macros.svh"

module dfgw_checker import dfgw_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             cmd_valid,
	input logic             cmd_ready,
	input logic [ACT_W-1:0] cmd_action,
	input logic             visit_valid,
	input logic             visit_ready,
	input logic [VTX_W-1:0] visit_vertex,
	input logic             visit_last,
	input logic             visit_drop
);

	// hold a stalled item
	`DFGW_ASSERT_NXT(a_stall_hold, visit_valid && !visit_ready, visit_valid && $stable(visit_vertex) && $stable(visit_last) && $stable(visit_drop), "stalled item changed")

	// a walk still in progress takes no new item
	`DFGW_ASSERT_IMP(a_walk_busy, visit_valid && !visit_last, !cmd_ready, "item taken during walk")

	// clear and ignored items leave the input ready for the next item
	`DFGW_ASSERT_NXT(a_quick_item, cmd_valid && cmd_ready && (cmd_action == ACT_CLEAR || cmd_action == ACT_IGNORE), cmd_ready, "clear item stalled input")

endmodule

bind depth_first_graph_walk_top dfgw_checker u_dfgw_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cmd_valid    (cmd.valid),
	.cmd_ready    (cmd.ready),
	.cmd_action   (cmd.action),
	.visit_valid  (visit.valid),
	.visit_ready  (visit.ready),
	.visit_vertex (visit.vertex),
	.visit_last   (visit.last),
	.visit_drop   (visit.edges_dropped)
);

// ===== verif/tb_depth_first_graph_walk_top.sv =====
module tb_depth_first_graph_walk_top import dfgw_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_VERTICES = 64;
	localparam int DEGREE_CAP   = 8;
	localparam int IDLE_PCT     = 34;
	localparam int STALL_LIMIT  = 20000;
	localparam int DRAIN_CYCLES = 32;
	localparam int RANDOM_ITEMS = 90;

	typedef struct packed {
		logic [VTX_W-1:0] vertex;
		logic             last;
		logic             edges_dropped;
	} visit_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit steady = 1'b0;
	int errors = 0;
	int quiet_cycles = 0;
	int random_items = 0;

	logic [VTX_W-1:0] adj [NUM_VERTICES][DEGREE_CAP];
	int adj_len [NUM_VERTICES] = '{default: 0};
	bit dropped_seen = 1'b0;
	visit_t visit_order [$];

	dfgw_cmd_if   cmd_ch ();
	dfgw_visit_if visit_ch ();

	depth_first_graph_walk_top #(
		.VERTICES   (NUM_VERTICES),
		.MAX_DEGREE (DEGREE_CAP)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.visit  (visit_ch)
	);

	always #10 clk = ~clk;

	function automatic void walk_graph(input logic [VTX_W-1:0] start);
		logic [VTX_W-1:0] pend [$];
		logic [VTX_W-1:0] order [$];
		bit seen [NUM_VERTICES];
		logic [VTX_W-1:0] u;
		visit_t item;
		foreach (seen[i]) seen[i] = 1'b0;
		pend.push_back(start);
		while (pend.size() > 0) begin
			u = pend.pop_back();
			if (!seen[u]) begin
				seen[u] = 1'b1;
				order.push_back(u);
				for (int k = 0; k < adj_len[u]; k++)
					if (!seen[adj[u][k]]) pend.push_back(adj[u][k]);
			end
		end
		for (int i = 0; i < order.size(); i++) begin
			item.vertex = order[i];
			item.last = (i == order.size() - 1);
			item.edges_dropped = dropped_seen;
			visit_order.push_back(item);
		end
	endfunction

	function automatic void apply_graph_item(input logic [ACT_W-1:0] act,
			input logic [VTX_W-1:0] src, input logic [VTX_W-1:0] dst);
		case (act)
			ACT_APPEND: begin
				if (adj_len[src] >= DEGREE_CAP) begin
					dropped_seen = 1'b1;
				end else begin
					adj[src][adj_len[src]] = dst;
					adj_len[src]++;
				end
			end
			ACT_CLEAR: begin
				foreach (adj_len[i]) adj_len[i] = 0;
				dropped_seen = 1'b0;
			end
			ACT_SEARCH: walk_graph(src);
			default: ;
		endcase
	endfunction

	task automatic send_item(input logic [ACT_W-1:0] act, input logic [VTX_W-1:0] src,
			input logic [VTX_W-1:0] dst);
		if (!steady) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				cmd_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.action <= act;
		cmd_ch.from_vertex <= src;
		cmd_ch.to_vertex <= dst;
		do @(posedge clk); while (!cmd_ch.ready);
		apply_graph_item(act, src, dst);
	endtask

	task automatic test_empty_graph();
		send_item(ACT_SEARCH, 6'd0, 6'd0);
		send_item(ACT_SEARCH, 6'd63, 6'd63);
	endtask

	task automatic test_small_graph();
		send_item(ACT_APPEND, 6'd0, 6'd1);
		send_item(ACT_APPEND, 6'd0, 6'd2);
		send_item(ACT_APPEND, 6'd1, 6'd3);
		send_item(ACT_APPEND, 6'd2, 6'd3);
		send_item(ACT_APPEND, 6'd3, 6'd0);
		send_item(ACT_APPEND, 6'd2, 6'd2);
		send_item(ACT_APPEND, 6'd63, 6'd0);
		send_item(ACT_SEARCH, 6'd0, 6'd63);
		send_item(ACT_SEARCH, 6'd63, 6'd0);
	endtask

	task automatic test_full_list();
		for (int i = 0; i <= DEGREE_CAP; i++)
			send_item(ACT_APPEND, 6'd5, VTX_W'(10 + i));
		send_item(ACT_SEARCH, 6'd5, 6'd0);
	endtask

	task automatic test_unused_action();
		send_item(ACT_IGNORE, 6'd63, 6'd63);
		send_item(ACT_SEARCH, 6'd5, 6'd63);
	endtask

	task automatic test_clear();
		send_item(ACT_CLEAR, 6'd63, 6'd63);
		send_item(ACT_SEARCH, 6'd5, 6'd0);
	endtask

	task automatic build_and_walk(input int min_span, input int max_span, input int min_edges,
			input int max_edges);
		logic [VTX_W-1:0] base;
		logic [VTX_W-1:0] src;
		logic [VTX_W-1:0] dst;
		int span;
		int edges;
		int searches;
		base = VTX_W'($urandom);
		span = $urandom_range(max_span, min_span);
		edges = $urandom_range(max_edges, min_edges);
		searches = $urandom_range(3, 1);
		repeat (edges) begin
			case ($urandom_range(19))
				0: send_item(ACT_IGNORE, VTX_W'($urandom), VTX_W'($urandom));
				1: begin
					send_item(ACT_APPEND, VTX_W'($urandom), VTX_W'($urandom));
					random_items++;
				end
				default: begin
					src = ($urandom_range(4) == 0) ? base :
						base + VTX_W'($urandom_range(span - 1));
					dst = base + VTX_W'($urandom_range(span - 1));
					send_item(ACT_APPEND, src, dst);
					random_items++;
				end
			endcase
		end
		repeat (searches) begin
			src = ($urandom_range(4) == 0) ? VTX_W'($urandom) :
				base + VTX_W'($urandom_range(span - 1));
			send_item(ACT_SEARCH, src, VTX_W'($urandom));
			random_items++;
		end
	endtask

	task automatic test_steady_burst();
		steady = 1'b1;
		send_item(ACT_CLEAR, VTX_W'($urandom), VTX_W'($urandom));
		random_items++;
		build_and_walk(10, 12, 20, 24);
		steady = 1'b0;
	endtask

	task automatic test_random_graphs();
		while (random_items < RANDOM_ITEMS) begin
			if ($urandom_range(3) == 0) begin
				send_item(ACT_CLEAR, VTX_W'($urandom), VTX_W'($urandom));
				random_items++;
			end
			build_and_walk(4, 16, 8, 24);
		end
	endtask

	always @(posedge clk) begin
		visit_t want;
		visit_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		if (arst_n && visit_ch.valid && visit_ch.ready) begin
			if (visit_order.size() == 0) begin
				$display("%0t: expected no result, got vertex %0d last %0b dropped %0b",
					$time, visit_ch.vertex, visit_ch.last, visit_ch.edges_dropped);
				errors++;
			end else begin
				want = visit_order.pop_front();
				if (visit_ch.vertex !== want.vertex) begin
					$display("%0t: vertex expected %0d got %0d", $time, want.vertex,
						visit_ch.vertex);
					errors++;
				end
				if (visit_ch.last !== want.last) begin
					$display("%0t: last expected %0b got %0b", $time, want.last,
						visit_ch.last);
					errors++;
				end
				if (visit_ch.edges_dropped !== want.edges_dropped) begin
					$display("%0t: edges_dropped expected %0b got %0b", $time,
						want.edges_dropped, visit_ch.edges_dropped);
					errors++;
				end
			end
		end
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (visit_ch.valid && visit_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("depth_first_graph_walk_top regression: fail");
			$finish;
		end
	end

	initial begin
		cmd_ch.valid = 1'b0;
		cmd_ch.action = ACT_IGNORE;
		cmd_ch.from_vertex = '0;
		cmd_ch.to_vertex = '0;
		visit_ch.ready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_graph();
		test_small_graph();
		test_full_list();
		test_unused_action();
		test_clear();
		test_steady_burst();
		test_random_graphs();
		cmd_ch.valid <= 1'b0;
		while (visit_order.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("depth_first_graph_walk_top regression: pass");
		else
			$display("depth_first_graph_walk_top regression: fail");
		$finish;
	end

endmodule
